// ===== src/usdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// usdt_pkg
// Shared types and constants for the microsecond timebase deadline tracker.
// ============================================================================
package usdt_pkg;

    // Width of cycle counts and microsecond times; all of them wrap at this width.
    localparam int COUNT_BITS = 32;
    typedef logic [COUNT_BITS-1:0] t_cnt;

    // Field and register widths.
    localparam int ACTION_W   = 2;
    localparam int CYCLE_W    = 32;
    localparam int OUT_W      = 32;
    localparam int LATE_W     = 16;
    localparam int CPU_W      = 10;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // The shared divider takes divisors of up to this many bits.
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(COUNT_BITS + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(COUNT_BITS);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US     = 2'd1;
    localparam logic [CPU_W-1:0]     CPU_RESET         = 10'd1;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET      = 16'd1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESYNC = 2'd0,
        ACT_READ   = 2'd1,
        ACT_START  = 2'd2,
        ACT_CHECK  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_US_DIV,
        ST_EVAL,
        ST_PER_DIV,
        ST_FINISH
    } t_state;

    // Request into the shared divider.
    typedef struct packed {
        logic             start;
        t_cnt             dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    // Response from the shared divider; quotient and remainder are valid with done.
    typedef struct packed {
        logic             done;
        t_cnt             quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== src/usdt_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// usdt_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ============================================================================
module usdt_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire usdt_pkg::t_div_req i_req,
    output usdt_pkg::t_div_rsp      o_rsp
);
    import usdt_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_cnt                 r_quo, n_quo;
    logic [DVS_W-1:0]     r_rem, n_rem;
    logic [DVS_W-1:0]     r_dvs, n_dvs;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           fits;

    // The partial remainder stays below the divisor, so DVS_W + 1 bits hold the shift.
    assign shifted = {r_rem, r_quo[COUNT_BITS-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_STEPS;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[COUNT_BITS-2:0], fits};
            n_rem = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire

// ===== src/us_timebase_deadline_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// us_timebase_deadline_tracker_core
// Converts a free-running cycle count to microseconds and tracks a periodic
// deadline, using one shared iterative divider.
// ============================================================================
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  --------------------------------
//  in       into core  i_in_valid / o_in_stall    i_action, i_cycle_count
//  out      out of     o_out_valid / i_out_stall  o_now_us, o_elapsed_periods,
//           core                                  o_late_us
//  cfg      into core  i_cfg_we                   i_cfg_index, i_cfg_data
//
//  A result moves to the output register once the divider has converted cycles to
//  microseconds at one quotient bit per cycle. The input stalls until the result moves
//  to the output register, so the core takes no new item while the last one is still
//  at work.
//  A check that finds the deadline passed divides a second time by the period before
//  its result goes to the output register.
//  Reset is synchronous and active low; it clears the references, the deadline and
//  the handshake state, and sets the registers to their reset values. The input
//  stalls while reset is held.
//  A result that waits on i_out_stall holds the core in its last step; the next
//  item can be taken while the previous result still waits in the output register.
//
module us_timebase_deadline_tracker_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [usdt_pkg::ACTION_W-1:0]    i_action,
    input  wire logic [usdt_pkg::CYCLE_W-1:0]     i_cycle_count,
    // Output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [usdt_pkg::OUT_W-1:0]            o_now_us,
    output logic [usdt_pkg::OUT_W-1:0]            o_elapsed_periods,
    output logic [usdt_pkg::LATE_W-1:0]           o_late_us,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [usdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [usdt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import usdt_pkg::*;

    // Sequencer state.
    t_state r_state, n_state;

    // Configuration registers.
    logic [CPU_W-1:0]    r_cpu;
    logic [PERIOD_W-1:0] r_period;

    // Timebase state, all modulo 2^COUNT_BITS.
    t_cnt r_ref_cycles, n_ref_cycles;
    t_cnt r_ref_micros, n_ref_micros;
    t_cnt r_deadline, n_deadline;

    // The item at work and its partial results.
    t_action           r_action, n_action;
    t_cnt              r_cyc, n_cyc;
    t_cnt              r_now, n_now;
    t_cnt              r_periods, n_periods;
    logic [LATE_W-1:0] r_late, n_late;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_now, n_out_now;
    logic [OUT_W-1:0]  r_out_periods, n_out_periods;
    logic [LATE_W-1:0] r_out_late, n_out_late;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_xfer;
    logic out_free;
    t_cnt whole_us;
    t_cnt delta;
    t_cnt period_ext;

    usdt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign period_ext = t_cnt'(r_period);

    // A zero divisor counts no whole microseconds.
    assign whole_us = (r_cpu == '0) ? '0 : div_rsp.quotient;

    // Signed distance from the deadline to now; positive means the deadline passed.
    assign delta = r_now - r_deadline;

    always_comb begin
        n_state       = r_state;
        n_ref_cycles  = r_ref_cycles;
        n_ref_micros  = r_ref_micros;
        n_deadline    = r_deadline;
        n_action      = r_action;
        n_cyc         = r_cyc;
        n_now         = r_now;
        n_periods     = r_periods;
        n_late        = r_late;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_now     = r_out_now;
        n_out_periods = r_out_periods;
        n_out_late    = r_out_late;
        div_req       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_action         = t_action'(i_action);
                    n_cyc            = t_cnt'(i_cycle_count);
                    div_req.start    = 1'b1;
                    div_req.dividend = t_cnt'(i_cycle_count) - r_ref_cycles;
                    div_req.divisor  = DVS_W'(r_cpu);
                    n_state          = ST_US_DIV;
                end
            end
            ST_US_DIV: begin
                if (div_rsp.done) begin
                    n_now = r_ref_micros + whole_us;
                    // Folding d whole microseconds moves the cycle reference by
                    // d * divisor, which equals the elapsed cycles less the remainder.
                    if (r_action == ACT_RESYNC && r_cpu != '0) begin
                        n_ref_cycles = r_cyc - t_cnt'(div_rsp.remainder);
                        n_ref_micros = r_ref_micros + whole_us;
                    end
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_periods = '0;
                n_late    = '0;
                n_state   = ST_FINISH;
                unique case (r_action)
                    ACT_START: begin
                        n_deadline = r_now + period_ext;
                    end
                    ACT_CHECK: begin
                        n_periods = t_cnt'(1);
                        if (delta != '0 && !delta[COUNT_BITS-1] && r_period != '0) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = delta;
                            div_req.divisor  = DVS_W'(r_period);
                            n_state          = ST_PER_DIV;
                        end else begin
                            // On time, or no period: one period, which may be zero.
                            n_deadline = r_deadline + period_ext;
                        end
                    end
                    ACT_RESYNC, ACT_READ: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_PER_DIV: begin
                if (div_rsp.done) begin
                    n_periods  = div_rsp.quotient + t_cnt'(1);
                    n_late     = LATE_W'(div_rsp.remainder);
                    // Advancing by (1 + q) periods lands at now + period - remainder.
                    n_deadline = r_now + period_ext - t_cnt'(div_rsp.remainder);
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_now     = OUT_W'(r_now);
                    n_out_periods = OUT_W'(r_periods);
                    n_out_late    = r_late;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_ref_cycles <= '0;
            r_ref_micros <= '0;
            r_deadline   <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_ref_cycles <= n_ref_cycles;
            r_ref_micros <= n_ref_micros;
            r_deadline   <= n_deadline;
        end
        r_action      <= n_action;
        r_cyc         <= n_cyc;
        r_now         <= n_now;
        r_periods     <= n_periods;
        r_late        <= n_late;
        r_out_now     <= n_out_now;
        r_out_periods <= n_out_periods;
        r_out_late    <= n_out_late;
    end

    // Configuration writes are expected only while the core is idle; other indexes
    // are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu    <= CPU_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CYCLES_PER_US: r_cpu    <= i_cfg_data[CPU_W-1:0];
                CFG_PERIOD_US:     r_period <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_now_us          = r_out_now;
    assign o_elapsed_periods = r_out_periods;
    assign o_late_us         = r_out_late;

endmodule
`default_nettype wire

// ===== src/usdt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// usdt_checker
// Port-level checks for the timebase deadline tracker, bound to the top level.
// ============================================================================
module usdt_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic [usdt_pkg::OUT_W-1:0]       o_now_us,
    input wire logic [usdt_pkg::OUT_W-1:0]       o_elapsed_periods,
    input wire logic [usdt_pkg::LATE_W-1:0]      o_late_us
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted item keeps the input side stalled while the divider starts its work.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall ##1 o_in_stall)
        else $error("input not stalled while an item is at work");

    // Lateness is only ever reported together with elapsed periods.
    a_late_needs_periods: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_elapsed_periods == '0) |-> (o_late_us == '0))
        else $error("lateness reported without a check");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_now_us) && $stable(o_elapsed_periods)
             && $stable(o_late_us)))
        else $error("stalled result changed");

endmodule

bind us_timebase_deadline_tracker_core usdt_checker u_usdt_checker (.*);
`default_nettype wire
